// ===== src/tcp_segment_reorder_top_defines.svh =====
// Assertion macros for the reorder buffer top module.
`ifndef TCP_SEGMENT_REORDER_TOP_DEFINES_SVH
`define TCP_SEGMENT_REORDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tsr_pkg.sv =====
`timescale 1ns / 1ps

package tsr_pkg;

	localparam logic [2:0] ACT_RELEASED  = 3'd0;
	localparam logic [2:0] ACT_HELD      = 3'd1;
	localparam logic [2:0] ACT_DUPLICATE = 3'd2;
	localparam logic [2:0] ACT_STALE     = 3'd3;
	localparam logic [2:0] ACT_FULL      = 3'd4;

	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] seg_end;
		logic [15:0] len;
		logic [15:0] handle;
	} cell_data_t;

	typedef struct packed {
		logic load_new;
		logic take_left;
		logic take_right;
	} cell_ctl_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic link;
	} cell_stat_t;

	typedef struct packed {
		logic insert;
		logic drain;
	} chain_cmd_t;

endpackage

// ===== src/tsr_cell.sv =====
`timescale 1ns / 1ps

module tsr_cell (
	input  logic               clk,
	input  tsr_pkg::cell_ctl_t  ctl,
	input  tsr_pkg::cell_data_t new_data,
	input  tsr_pkg::cell_data_t left_data,
	input  tsr_pkg::cell_data_t right_data,
	input  logic [31:0]        key_seq,
	input  logic [31:0]        prev_end,
	output tsr_pkg::cell_data_t data,
	output tsr_pkg::cell_stat_t stat
);
	import tsr_pkg::*;

	cell_data_t data_q;

	always_ff @(posedge clk) begin
		priority if (ctl.load_new) begin
			data_q <= new_data;
		end else if (ctl.take_left) begin
			data_q <= left_data;
		end else if (ctl.take_right) begin
			data_q <= right_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data      = data_q;
	assign stat.lt   = data_q.seq < key_seq;
	assign stat.eq   = data_q.seq == key_seq;
	assign stat.link = data_q.seq == prev_end;

endmodule

// ===== src/tsr_chain.sv =====
`timescale 1ns / 1ps

module tsr_chain #(
	parameter  int SLOTS = 16,
	localparam int CW    = $clog2(SLOTS + 1)
) (
	input  logic                clk,
	input  tsr_pkg::chain_cmd_t  cmd,
	input  tsr_pkg::cell_data_t  new_data,
	input  logic [CW-1:0]       count,
	output logic                eq_hit,
	output logic [SLOTS-1:0]    run,
	output logic [31:0]         run_end,
	output tsr_pkg::cell_data_t  head
);
	import tsr_pkg::*;

	cell_data_t        cell_d [SLOTS];
	cell_stat_t        stat   [SLOTS];
	cell_ctl_t         ctl    [SLOTS];
	logic [SLOTS-1:0]  occ;
	logic [SLOTS-1:0]  lt_g;
	logic [SLOTS-1:0]  eq_g;
	logic [SLOTS-1:0]  link_g;
	logic [SLOTS-1:0]  tail;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		localparam logic [SLOTS-1:0] LOW_MASK = {SLOTS{1'b1}} >> (SLOTS - 1 - i);
		cell_data_t  left_d;
		cell_data_t  right_d;
		logic [31:0] prev_end;
		logic        prev_lt;

		if (i == 0) begin : g_first
			assign left_d   = new_data;
			assign prev_end = new_data.seg_end;
			assign prev_lt  = 1'b1;
		end else begin : g_mid
			assign left_d   = cell_d[i-1];
			assign prev_end = cell_d[i-1].seg_end;
			assign prev_lt  = lt_g[i-1];
		end

		if (i == SLOTS - 1) begin : g_last
			assign right_d = cell_d[i];
			assign tail[i] = run[i];
		end else begin : g_body
			assign right_d = cell_d[i+1];
			assign tail[i] = run[i] & ~run[i+1];
		end

		assign occ[i]    = CW'(i) < count;
		assign lt_g[i]   = occ[i] & stat[i].lt;
		assign eq_g[i]   = occ[i] & stat[i].eq;
		assign link_g[i] = occ[i] & stat[i].link;
		assign run[i]    = &(link_g | ~LOW_MASK);

		assign ctl[i].load_new   = cmd.insert & ~lt_g[i] & prev_lt;
		assign ctl[i].take_left  = cmd.insert & ~lt_g[i] & ~prev_lt;
		assign ctl[i].take_right = cmd.drain;

		tsr_cell u_cell (
			.clk        (clk),
			.ctl        (ctl[i]),
			.new_data   (new_data),
			.left_data  (left_d),
			.right_data (right_d),
			.key_seq    (new_data.seq),
			.prev_end   (prev_end),
			.data       (cell_d[i]),
			.stat       (stat[i])
		);
	end

	always_comb begin
		run_end = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (tail[k]) begin
				run_end = run_end | cell_d[k].seg_end;
			end
		end
		if (!run[0]) begin
			run_end = new_data.seg_end;
		end
	end

	assign eq_hit = |eq_g;
	assign head   = cell_d[0];

endmodule

// ===== src/tcp_segment_reorder_top.sv =====
// TCP segment reorder buffer.
// Segment descriptors come in on the seg channel (seg_valid / seg_stall) with
// direction, seq, seg_length and buffer_handle. Result words leave on the res
// channel (res_valid / res_stall); every word carries an action code, the
// reported segment, next_expected of its direction and last on its final word.
// Each direction keeps its pending segments in a sorted chain of cells.
// An item is registered on acceptance and classified in the decide state,
// where an insert into the chain also completes. A release gives its first
// word in that decide step and then drains one pending segment per cycle
// while res_stall is low.
// One item is in work at a time; seg_stall is high from acceptance until the
// last word of the item is loaded into the output register.
// When res_stall is high the output register holds its word and the block
// waits; the next item may be accepted while the final word still waits.
// Reset clears the expected sequences and pending counts of both directions.
`timescale 1ns / 1ps
`include "tcp_segment_reorder_top_defines.svh"

module tcp_segment_reorder_top #(
	parameter int SLOTS_PER_DIRECTION = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seg_valid,
	output logic        seg_stall,
	input  logic        direction,
	input  logic [31:0] seq,
	input  logic [15:0] seg_length,
	input  logic [15:0] buffer_handle,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  action,
	output logic        out_direction,
	output logic [31:0] out_seq,
	output logic [15:0] out_length,
	output logic [15:0] out_handle,
	output logic [31:0] next_expected,
	output logic        last
);
	import tsr_pkg::*;

	localparam int SLOTS = SLOTS_PER_DIRECTION;
	localparam int CW    = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DECIDE = 3'b010,
		ST_DRAIN  = 3'b100
	} state_t;

	state_t                state_q;
	logic                  res_valid_q;
	logic [1:0][31:0]      exp_q;
	logic [1:0][CW-1:0]    cnt_q;

	logic                  dir_s1;
	logic [31:0]           seq_s1;
	logic [15:0]           len_s1;
	logic [15:0]           hnd_s1;
	logic [31:0]           end_s1;

	logic [SLOTS-1:0]      drain_q;
	logic                  ddir_q;
	logic [31:0]           nexp_q;

	logic [2:0]            action_q;
	logic                  out_dir_q;
	logic [31:0]           out_seq_q;
	logic [15:0]           out_len_q;
	logic [15:0]           out_hnd_q;
	logic [31:0]           out_nexp_q;
	logic                  last_q;

	cell_data_t            new_data;
	chain_cmd_t            cmd    [2];
	logic [1:0]            eq_hit;
	logic [SLOTS-1:0]      run    [2];
	logic [31:0]           run_end [2];
	cell_data_t            head   [2];

	logic                  accept;
	logic                  out_free;
	logic                  decide_fire;
	logic                  drain_fire;
	logic [31:0]           cur_exp;
	logic [CW-1:0]         cur_cnt;
	logic                  is_rel;
	logic [2:0]            dec_act;
	logic [SLOTS-1:0]      cur_run;

	assign seg_stall   = state_q != ST_IDLE;
	assign accept      = seg_valid & ~seg_stall;
	assign out_free    = ~res_valid_q | ~res_stall;
	assign decide_fire = (state_q == ST_DECIDE) & out_free;
	assign drain_fire  = (state_q == ST_DRAIN) & out_free;

	assign new_data.seq     = seq_s1;
	assign new_data.seg_end = end_s1;
	assign new_data.len     = len_s1;
	assign new_data.handle  = hnd_s1;

	assign cur_exp = exp_q[dir_s1];
	assign cur_cnt = cnt_q[dir_s1];
	assign cur_run = run[dir_s1];
	assign is_rel  = (cur_exp == '0) | (cur_exp == seq_s1);

	always_comb begin
		priority if (is_rel) begin
			dec_act = ACT_RELEASED;
		end else if (seq_s1 < cur_exp) begin
			dec_act = ACT_STALE;
		end else if (eq_hit[dir_s1]) begin
			dec_act = ACT_DUPLICATE;
		end else if (cur_cnt == CW'(SLOTS)) begin
			dec_act = ACT_FULL;
		end else begin
			dec_act = ACT_HELD;
		end
	end

	for (genvar d = 0; d < 2; d++) begin : g_dir
		assign cmd[d].insert = decide_fire & (dec_act == ACT_HELD) & (dir_s1 == 1'(d));
		assign cmd[d].drain  = drain_fire & (ddir_q == 1'(d));

		tsr_chain #(
			.SLOTS (SLOTS)
		) u_chain (
			.clk      (clk),
			.cmd      (cmd[d]),
			.new_data (new_data),
			.count    (cnt_q[d]),
			.eq_hit   (eq_hit[d]),
			.run      (run[d]),
			.run_end  (run_end[d]),
			.head     (head[d])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			exp_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_free) begin
				res_valid_q <= decide_fire | drain_fire;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (decide_fire) begin
						if (dec_act == ACT_RELEASED) begin
							exp_q[dir_s1] <= run_end[dir_s1];
						end
						if (dec_act == ACT_HELD) begin
							cnt_q[dir_s1] <= cnt_q[dir_s1] + 1'b1;
						end
						state_q <= (is_rel & cur_run[0]) ? ST_DRAIN : ST_IDLE;
					end
				end
				ST_DRAIN: begin
					if (drain_fire) begin
						cnt_q[ddir_q] <= cnt_q[ddir_q] - 1'b1;
						if (!drain_q[1]) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dir_s1 <= direction;
			seq_s1 <= seq;
			len_s1 <= seg_length;
			hnd_s1 <= buffer_handle;
			end_s1 <= seq + 32'(seg_length);
		end
		if (decide_fire) begin
			drain_q    <= cur_run;
			ddir_q     <= dir_s1;
			nexp_q     <= run_end[dir_s1];
			action_q   <= dec_act;
			out_dir_q  <= dir_s1;
			out_seq_q  <= seq_s1;
			out_len_q  <= len_s1;
			out_hnd_q  <= hnd_s1;
			out_nexp_q <= is_rel ? run_end[dir_s1] : cur_exp;
			last_q     <= ~(is_rel & cur_run[0]);
		end else if (drain_fire) begin
			drain_q    <= drain_q >> 1;
			action_q   <= ACT_RELEASED;
			out_dir_q  <= ddir_q;
			out_seq_q  <= head[ddir_q].seq;
			out_len_q  <= head[ddir_q].len;
			out_hnd_q  <= head[ddir_q].handle;
			out_nexp_q <= nexp_q;
			last_q     <= ~drain_q[1];
		end
	end

	assign res_valid     = res_valid_q;
	assign action        = action_q;
	assign out_direction = out_dir_q;
	assign out_seq       = out_seq_q;
	assign out_length    = out_len_q;
	assign out_handle    = out_hnd_q;
	assign next_expected = out_nexp_q;
	assign last          = last_q;

	`TSR_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, (cnt_q[0] <= CW'(SLOTS)) && (cnt_q[1] <= CW'(SLOTS)), "pending count above table size")
	`TSR_ASSERT_IMPL(a_drain_head, clk, arst_n, state_q == ST_DRAIN, drain_q[0] && (cnt_q[ddir_q] != '0), "drain without a pending head")
	`TSR_ASSERT_NEXT(a_drain_end, clk, arst_n, drain_fire && !drain_q[1], state_q == ST_IDLE, "drain did not finish on last word")
	`TSR_ASSERT_NEXT(a_insert_cnt, clk, arst_n, cmd[0].insert, cnt_q[0] == CW'($past(cnt_q[0]) + 1'b1), "insert did not grow table")

endmodule

// ===== test/tcp_segment_reorder_top_tb.sv =====
`timescale 1ns / 1ps

module tcp_segment_reorder_top_tb;
	import tsr_pkg::*;

	localparam int SLOTS = 16;
	localparam int RANDOM_WORDS = 460;
	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic        dir;
		logic [31:0] seq;
		logic [15:0] len;
		logic [15:0] hnd;
		logic        typed;
		logic [2:0]  act;
		logic [31:0] nexp;
	} seg_word_t;

	typedef struct packed {
		logic [2:0]  act;
		logic        dir;
		logic [31:0] seq;
		logic [15:0] len;
		logic [15:0] hnd;
		logic [31:0] nexp;
		logic        last;
	} res_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        seg_valid = 1'b0;
	logic        seg_stall;
	logic        direction = 1'b0;
	logic [31:0] seq = '0;
	logic [15:0] seg_length = '0;
	logic [15:0] buffer_handle = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [2:0]  action;
	logic        out_direction;
	logic [31:0] out_seq;
	logic [15:0] out_length;
	logic [15:0] out_handle;
	logic [31:0] next_expected;
	logic        last;

	tcp_segment_reorder_top #(
		.SLOTS_PER_DIRECTION(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.direction(direction),
		.seq(seq),
		.seg_length(seg_length),
		.buffer_handle(buffer_handle),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.action(action),
		.out_direction(out_direction),
		.out_seq(out_seq),
		.out_length(out_length),
		.out_handle(out_handle),
		.next_expected(next_expected),
		.last(last)
	);

	always #4 clk = ~clk;

	// shadow of the block state
	logic [31:0] stream_exp [2];
	int          pend_cnt [2];
	logic [31:0] pend_seq [2][SLOTS];
	logic [15:0] pend_len [2][SLOTS];
	logic [15:0] pend_hnd [2][SLOTS];

	res_word_t   due_words [$];
	seg_word_t   send_q [$];
	seg_word_t   cur_word;
	int          mismatches = 0;
	int          cycle_cnt = 0;
	bit          quiet = 0;
	bit          hold_req = 0;

	// typed rows: act / nexp give the first word expected
	seg_word_t directed_rows [17] = '{
		'{1'b0, 32'd1000, 16'd100, 16'h0001, 1'b1, ACT_RELEASED, 32'd1100},
		'{1'b0, 32'd1300, 16'd100, 16'h0002, 1'b1, ACT_HELD, 32'd1100},
		'{1'b0, 32'd1200, 16'd100, 16'h0003, 1'b1, ACT_HELD, 32'd1100},
		'{1'b0, 32'd1200, 16'd7, 16'h0004, 1'b1, ACT_DUPLICATE, 32'd1100},
		'{1'b0, 32'd500, 16'd50, 16'h0005, 1'b1, ACT_STALE, 32'd1100},
		'{1'b0, 32'd1100, 16'd100, 16'h0006, 1'b0, ACT_RELEASED, 32'd0},
		'{1'b0, 32'd1400, 16'd0, 16'h0007, 1'b1, ACT_RELEASED, 32'd1400},
		'{1'b0, 32'd1400, 16'd60, 16'h0008, 1'b1, ACT_RELEASED, 32'd1460},
		'{1'b1, 32'hFFFF_FF00, 16'h10, 16'h0009, 1'b1, ACT_RELEASED, 32'hFFFF_FF10},
		'{1'b1, 32'hFFFF_FF20, 16'h10, 16'h000A, 1'b1, ACT_HELD, 32'hFFFF_FF10},
		'{1'b1, 32'hFFFF_FF10, 16'h20, 16'h000B, 1'b1, ACT_RELEASED, 32'hFFFF_FF30},
		'{1'b1, 32'hFFFF_FF20, 16'h5, 16'h000C, 1'b1, ACT_STALE, 32'hFFFF_FF30},
		'{1'b1, 32'hFFFF_FF30, 16'hD0, 16'h000D, 1'b1, ACT_RELEASED, 32'h0},
		'{1'b1, 32'hFFFF_FF00, 16'h20, 16'h000E, 1'b0, ACT_RELEASED, 32'd0},
		'{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, ACT_HELD, 32'hFFFF_FF30},
		'{1'b1, 32'hFFFF_FF30, 16'hCF, 16'h0010, 1'b0, ACT_RELEASED, 32'd0},
		'{1'b1, 32'h0, 16'h0, 16'h0, 1'b1, ACT_STALE, 32'h0000_FFFE}
	};

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic void push_due(input logic [2:0] act, input logic d,
			input logic [31:0] s, input logic [15:0] len, input logic [15:0] hnd,
			input logic [31:0] nexp, input logic lst);
		res_word_t r;
		r = '{act, d, s, len, hnd, nexp, lst};
		due_words.push_back(r);
	endfunction

	task automatic reorder_predict(input seg_word_t w);
		logic        d;
		logic [31:0] nexp;
		int          n, i, pos, first;
		d = w.dir;
		first = due_words.size();
		if (stream_exp[d] == 0 || stream_exp[d] == w.seq) begin
			nexp = w.seq + {16'd0, w.len};
			n = 0;
			while (n < pend_cnt[d] && pend_seq[d][n] == nexp) begin
				nexp = nexp + {16'd0, pend_len[d][n]};
				n++;
			end
			push_due(ACT_RELEASED, d, w.seq, w.len, w.hnd, nexp, n == 0);
			for (i = 0; i < n; i++)
				push_due(ACT_RELEASED, d, pend_seq[d][i], pend_len[d][i], pend_hnd[d][i],
					nexp, i + 1 == n);
			for (i = n; i < pend_cnt[d]; i++) begin
				pend_seq[d][i - n] = pend_seq[d][i];
				pend_len[d][i - n] = pend_len[d][i];
				pend_hnd[d][i - n] = pend_hnd[d][i];
			end
			pend_cnt[d] -= n;
			stream_exp[d] = nexp;
		end else if (w.seq < stream_exp[d]) begin
			push_due(ACT_STALE, d, w.seq, w.len, w.hnd, stream_exp[d], 1'b1);
		end else begin
			pos = 0;
			while (pos < pend_cnt[d] && pend_seq[d][pos] < w.seq)
				pos++;
			if (pos < pend_cnt[d] && pend_seq[d][pos] == w.seq) begin
				push_due(ACT_DUPLICATE, d, w.seq, w.len, w.hnd, stream_exp[d], 1'b1);
			end else if (pend_cnt[d] >= SLOTS) begin
				push_due(ACT_FULL, d, w.seq, w.len, w.hnd, stream_exp[d], 1'b1);
			end else begin
				for (i = pend_cnt[d]; i > pos; i--) begin
					pend_seq[d][i] = pend_seq[d][i - 1];
					pend_len[d][i] = pend_len[d][i - 1];
					pend_hnd[d][i] = pend_hnd[d][i - 1];
				end
				pend_seq[d][pos] = w.seq;
				pend_len[d][pos] = w.len;
				pend_hnd[d][pos] = w.hnd;
				pend_cnt[d]++;
				push_due(ACT_HELD, d, w.seq, w.len, w.hnd, stream_exp[d], 1'b1);
			end
		end
		if (w.typed) begin
			due_words[first].act = w.act;
			due_words[first].nexp = w.nexp;
		end
	endtask

	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(31, 0);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'hFFFF;
		if (r == 2)
			return 16'($urandom_range(65535, 0));
		return 16'($urandom_range(1460, 1));
	endfunction

	function automatic seg_word_t make_word(input logic d, input logic [31:0] s,
			input logic [15:0] len);
		seg_word_t w;
		w = '{d, s, len, 16'($urandom_range(65535, 0)), 1'b0, ACT_RELEASED, 32'd0};
		return w;
	endfunction

	// One stream segment run for one direction: fill the holes before the
	// pending segments, extend the stream, then reorder and add noise.
	task automatic plan_stream();
		seg_word_t   segs [$];
		seg_word_t   w, head;
		logic        d;
		logic [31:0] cursor, gap;
		logic [15:0] len;
		int          k, j, n_new, n_noise;
		bit          started, big, inorder;
		d = 1'($urandom_range(1, 0));
		started = stream_exp[d] != 0;
		cursor = stream_exp[d];
		if (!started) begin
			if (pend_cnt[d] != 0 && pend_seq[d][0] > 100)
				cursor = pend_seq[d][0] - $urandom_range(100, 1);
			else
				cursor = $urandom_range(32'hFFC0_0000, 1);
		end
		for (k = 0; k < pend_cnt[d]; k++) begin
			if (pend_seq[d][k] >= cursor) begin
				while (cursor != pend_seq[d][k]) begin
					gap = pend_seq[d][k] - cursor;
					len = (gap > 32'hFFFF) ? 16'($urandom_range(1460, 1)) : gap[15:0];
					segs.push_back(make_word(d, cursor, len));
					cursor = cursor + {16'd0, len};
				end
				cursor = pend_seq[d][k] + {16'd0, pend_len[d][k]};
			end
		end
		big = $urandom_range(9, 0) == 0;
		n_new = big ? $urandom_range(22, 17) : $urandom_range(6, 0);
		if (segs.size() == 0 && n_new == 0)
			n_new = 1;
		for (j = 0; j < n_new; j++) begin
			len = pick_len();
			// holes: skip a segment now and then
			if (segs.size() == 0 || $urandom_range(15, 0) != 0)
				segs.push_back(make_word(d, cursor, len));
			cursor = cursor + {16'd0, len};
		end
		head = segs.pop_front();
		inorder = $urandom_range(3, 0) == 0;
		if (!inorder || big) begin
			for (j = segs.size() - 1; j > 0; j--) begin
				k = $urandom_range(j, 0);
				w = segs[j];
				segs[j] = segs[k];
				segs[k] = w;
			end
		end
		if (big) begin
			// fill the table, hit it with a duplicate, then release it all
			if (segs.size() > 0) begin
				w = segs[$urandom_range(segs.size() - 1, 0)];
				w.hnd = 16'($urandom_range(65535, 0));
				segs.push_back(w);
			end
			segs.push_back(head);
		end else if (started && !inorder) begin
			segs.insert($urandom_range(segs.size(), 0), head);
		end else begin
			segs.push_front(head);
		end
		n_noise = $urandom_range(2, 0);
		for (j = 0; j < n_noise; j++) begin
			if (started && $urandom_range(1, 0) == 0) begin
				w = make_word(d, $urandom_range(stream_exp[d] - 1, 0), pick_len());
			end else begin
				w = segs[$urandom_range(segs.size() - 1, 0)];
				w.hnd = 16'($urandom_range(65535, 0));
			end
			segs.insert($urandom_range(segs.size(), 1), w);
		end
		foreach (segs[j])
			send_q.push_back(segs[j]);
	endtask

	task automatic send_word(input seg_word_t w);
		if (!quiet && $urandom_range(99, 0) < 20) begin
			seg_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		cur_word = w;
		seg_valid <= 1'b1;
		direction <= w.dir;
		seq <= w.seq;
		seg_length <= w.len;
		buffer_handle <= w.hnd;
		@(posedge clk);
		while (seg_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && seg_valid && !seg_stall)
			reorder_predict(cur_word);
	end

	always @(posedge clk) begin : check_words
		res_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (due_words.size() == 0) begin
				report_mismatch("unexpected word, seq", out_seq, 32'd0);
			end else begin
				want = due_words.pop_front();
				if (action !== want.act)
					report_mismatch("action", 32'(action), 32'(want.act));
				if (out_direction !== want.dir)
					report_mismatch("out_direction", 32'(out_direction), 32'(want.dir));
				if (out_seq !== want.seq)
					report_mismatch("out_seq", out_seq, want.seq);
				if (out_length !== want.len)
					report_mismatch("out_length", 32'(out_length), 32'(want.len));
				if (out_handle !== want.hnd)
					report_mismatch("out_handle", 32'(out_handle), 32'(want.hnd));
				if (next_expected !== want.nexp)
					report_mismatch("next_expected", next_expected, want.nexp);
				if (last !== want.last)
					report_mismatch("last", 32'(last), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side
	initial begin : res_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else if (quiet) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= $urandom_range(99, 0) < 20;
			end
		end
	end

	initial begin : seg_side
		int random_sent;
		stream_exp = '{32'd0, 32'd0};
		pend_cnt = '{0, 0};
		random_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_rows[i])
			send_word(directed_rows[i]);
		while (random_sent < RANDOM_WORDS) begin
			if (send_q.size() == 0)
				plan_stream();
			quiet = random_sent >= 180 && random_sent < 260;
			if (random_sent == 100)
				hold_req = 1;
			if (random_sent == 320) begin
				seg_valid <= 1'b0;
				while (due_words.size() != 0)
					@(negedge clk);
				@(negedge clk);
			end
			send_word(send_q.pop_front());
			random_sent++;
		end
		seg_valid <= 1'b0;
		while (due_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
